// File: rtl/ses_pkg.sv
// Package for the servo enable and home sequencer.
// Holds the item, result and register types, register indexes and status codes.
// No dependencies.
`default_nettype none

package ses_pkg;

  localparam int unsigned NumAxesDefault = 7;

  localparam int unsigned AxisW = 3;
  localparam int unsigned StatusW = 16;
  localparam int unsigned PosW = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned StepW = 16;
  localparam int unsigned RetryW = 4;
  localparam int unsigned CtrlW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgHomePosition = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHomeWindow = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHomeStep = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRetryReload = 2'd3;

  // register reset values
  localparam logic [PosW-1:0] HomePositionReset = 32'd0;
  localparam logic [WindowW-1:0] HomeWindowReset = 16'd80;
  localparam logic [StepW-1:0] HomeStepReset = 16'd120;
  localparam logic [RetryW-1:0] RetryReloadReset = 4'd5;
  localparam logic [RetryW-1:0] RetryCountReset = 4'd5;

  // status low byte codes
  localparam logic [7:0] StOpEnabled = 8'h37;
  localparam logic [7:0] StSwitchOnDisabled = 8'h50;
  localparam logic [7:0] StReadyToSwitchOn = 8'h31;
  localparam logic [7:0] StReadyToSwitchOnAlt = 8'h21;
  localparam logic [7:0] StSwitchedOn = 8'h33;

  // control words
  localparam logic [CtrlW-1:0] CwShutdown = 4'h6;
  localparam logic [CtrlW-1:0] CwSwitchOn = 4'h7;
  localparam logic [CtrlW-1:0] CwEnableOp = 4'hF;
  localparam logic [CtrlW-1:0] CwNone = 4'h0;

  typedef struct packed {
    logic [AxisW-1:0] axis;
    logic [StatusW-1:0] drive_status;
    logic signed [PosW-1:0] actual_position;
  } in_item_t;

  typedef struct packed {
    logic control_valid;
    logic [CtrlW-1:0] control_word;
    logic target_valid;
    logic signed [PosW-1:0] target_pos;
    logic axis_enabled;
    logic all_enabled;
    logic axis_homed;
  } out_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] home_position;
    logic [WindowW-1:0] home_window;
    logic [StepW-1:0] home_step;
    logic [RetryW-1:0] retry_reload;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/servo_enable_and_home_sequencer_top.sv
// Top level of the servo enable and home sequencer: register file,
// input register, result register. Depends on ses_pkg and ses_core.
`default_nettype none

// Takes one axis status item per cycle, sustained while the result side is
// not stalled. An accepted item waits in the input register until the
// result register takes its result; the per-axis state is read, updated
// and written back as it does, so consecutive items for the same axis need
// no extra spacing. Axes are expected in order 0 to NUM_AXES-1 in every
// sweep; the pass type is latched at axis 0. The user must write registers
// through the plain write port only while no item is in flight; the block
// itself does not enforce this.
module servo_enable_and_home_sequencer_top #(
  parameter int unsigned NumAxes = ses_pkg::NumAxesDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ses_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [ses_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire ses_pkg::in_item_t               in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output ses_pkg::out_item_t                   out_item_o
);

  ses_pkg::cfg_t      cfg_q;
  ses_pkg::in_item_t  in_q;
  logic               in_valid_q;
  ses_pkg::out_item_t out_q, res;
  logic               out_valid_q;
  logic               adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_position <= ses_pkg::HomePositionReset;
      cfg_q.home_window <= ses_pkg::HomeWindowReset;
      cfg_q.home_step <= ses_pkg::HomeStepReset;
      cfg_q.retry_reload <= ses_pkg::RetryReloadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ses_pkg::CfgHomePosition: cfg_q.home_position <= cfg_wdata_i;
        ses_pkg::CfgHomeWindow: cfg_q.home_window <= cfg_wdata_i[ses_pkg::WindowW-1:0];
        ses_pkg::CfgHomeStep: cfg_q.home_step <= cfg_wdata_i[ses_pkg::StepW-1:0];
        ses_pkg::CfgRetryReload: cfg_q.retry_reload <= cfg_wdata_i[ses_pkg::RetryW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  ses_core #(
    .NumAxes(NumAxes)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .step_i  (adv),
    .item_i  (in_q),
    .result_o(res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

endmodule

`default_nettype wire

// File: rtl/ses_core.sv
// Per-axis state and combinational step logic of the enable and home sequencer.
// Depends on ses_pkg.
`default_nettype none

module ses_core #(
  parameter int unsigned NumAxes = ses_pkg::NumAxesDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ses_pkg::cfg_t     cfg_i,
  input  wire logic              step_i,
  input  wire ses_pkg::in_item_t item_i,
  output ses_pkg::out_item_t     result_o
);

  localparam int unsigned IdxW = (NumAxes > 1) ? $clog2(NumAxes) : 1;
  localparam int unsigned PosW = ses_pkg::PosW;

  logic [ses_pkg::StatusW-1:0] prev_status_q [NumAxes];
  logic [ses_pkg::RetryW-1:0]  retry_q       [NumAxes];
  logic [NumAxes-1:0]          enabled_q;
  logic [NumAxes-1:0]          homed_q;
  logic [PosW-1:0]             target_q      [NumAxes];
  logic                        all_en_q, all_en_d;
  logic                        run_pass_q, run_pass_d;

  logic [IdxW-1:0]             idx;
  logic                        ok;
  logic [7:0]                  lo;
  logic                        en;
  logic [ses_pkg::StatusW-1:0] prev_d;
  logic [ses_pkg::RetryW-1:0]  cnt, retry_d;
  logic                        enabled_d, homed_d;
  logic [PosW-1:0]             target_d;
  logic                        all_and;
  logic signed [PosW+1:0]      act_x, hi_lim, lo_lim;

  assign idx = IdxW'(item_i.axis);
  assign ok = (int'(item_i.axis) < NumAxes);
  assign lo = item_i.drive_status[7:0];
  assign en = (lo == ses_pkg::StOpEnabled);
  assign run_pass_d = (item_i.axis == '0) ? all_en_q : run_pass_q;

  assign act_x = {{2{item_i.actual_position[PosW-1]}}, item_i.actual_position};
  assign hi_lim = {{2{cfg_i.home_position[PosW-1]}}, cfg_i.home_position}
                  + {{(PosW+2-ses_pkg::WindowW){1'b0}}, cfg_i.home_window};
  assign lo_lim = {{2{cfg_i.home_position[PosW-1]}}, cfg_i.home_position}
                  - {{(PosW+2-ses_pkg::WindowW){1'b0}}, cfg_i.home_window};

  always_comb begin
    prev_d = prev_status_q[idx];
    cnt = retry_q[idx];
    retry_d = cnt;
    enabled_d = enabled_q[idx];
    homed_d = homed_q[idx];
    target_d = target_q[idx];
    all_en_d = all_en_q;
    all_and = 1'b1;
    result_o = '0;
    result_o.axis_enabled = en;

    if (ok) begin
      if (!run_pass_d) begin
        if (prev_d != item_i.drive_status) begin
          prev_d = item_i.drive_status;
          cnt = cfg_i.retry_reload;
        end
        retry_d = cnt;
        if (!en) begin
          enabled_d = 1'b0;
          if (cnt == cfg_i.retry_reload) begin
            priority if (lo == ses_pkg::StSwitchOnDisabled) begin
              result_o.control_valid = 1'b1;
              result_o.control_word = ses_pkg::CwShutdown;
            end else if (lo == ses_pkg::StReadyToSwitchOn ||
                         lo == ses_pkg::StReadyToSwitchOnAlt) begin
              target_d = item_i.actual_position;
              result_o.target_valid = 1'b1;
              result_o.target_pos = item_i.actual_position;
              result_o.control_valid = 1'b1;
              result_o.control_word = ses_pkg::CwSwitchOn;
            end else if (lo == ses_pkg::StSwitchedOn) begin
              target_d = item_i.actual_position;
              result_o.target_valid = 1'b1;
              result_o.target_pos = item_i.actual_position;
              result_o.control_valid = 1'b1;
              result_o.control_word = ses_pkg::CwEnableOp;
            end else begin
            end
          end
          retry_d = (cnt == '0) ? cfg_i.retry_reload : cnt - 1'b1;
        end else begin
          enabled_d = 1'b1;
        end
        for (int i = 0; i < NumAxes; i++) begin
          all_and = all_and & ((IdxW'(i) == idx) ? enabled_d : enabled_q[i]);
        end
        if (int'(item_i.axis) == NumAxes - 1) begin
          all_en_d = all_and;
        end
      end else if (en && !homed_q[idx]) begin
        priority if (act_x > hi_lim) begin
          target_d = target_q[idx] - {{(PosW-ses_pkg::StepW){1'b0}}, cfg_i.home_step};
        end else if (act_x < lo_lim) begin
          target_d = target_q[idx] + {{(PosW-ses_pkg::StepW){1'b0}}, cfg_i.home_step};
        end else begin
          homed_d = 1'b1;
        end
        result_o.target_valid = 1'b1;
        result_o.target_pos = target_d;
      end
      result_o.axis_homed = homed_d;
    end
    result_o.all_enabled = all_en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        prev_status_q[i] <= '0;
        retry_q[i] <= ses_pkg::RetryCountReset;
        target_q[i] <= '0;
      end
      enabled_q <= '0;
      homed_q <= '0;
      all_en_q <= 1'b0;
      run_pass_q <= 1'b0;
    end else if (step_i && ok) begin
      prev_status_q[idx] <= prev_d;
      retry_q[idx] <= retry_d;
      target_q[idx] <= target_d;
      enabled_q[idx] <= enabled_d;
      homed_q[idx] <= homed_d;
      all_en_q <= all_en_d;
      run_pass_q <= run_pass_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/servo_enable_and_home_sequencer_top_tb.sv
// Self-checking testbench for servo_enable_and_home_sequencer_top.
// Drives enable and homing sweeps and checks every result item against
// a predictor or directed rows. Depends on ses_pkg and the sequencer RTL.
module servo_enable_and_home_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ses_pkg::*;

  localparam int unsigned NumAxes = NumAxesDefault;
  localparam logic [AxisW-1:0] SpareAxis = AxisW'(NumAxes);
  localparam longint IntMin = -64'sd2147483648;
  localparam longint IntMax = 64'sd2147483647;
  localparam int unsigned LongHold = 64;
  localparam int unsigned DirRows = 25;

  typedef struct packed {
    in_item_t item;
    logic typed;
    out_item_t want;
  } step_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  servo_enable_and_home_sequencer_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_item_i(in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o(out_item)
  );

  // predictor state
  cfg_t regs;
  logic [StatusW-1:0] seen_status [NumAxes];
  logic [RetryW-1:0] retry_left [NumAxes];
  logic [NumAxes-1:0] axis_on;
  logic [NumAxes-1:0] at_home;
  logic [PosW-1:0] target_hold [NumAxes];
  logic chain_enabled;
  logic run_sweep;

  out_item_t awaited_results [$];
  out_item_t oldest;
  logic [StatusW-1:0] held_status [NumAxes];
  step_row_t dir_rows [DirRows];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit gappy = 1'b1;
  bit calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("servo_enable_and_home_sequencer_top test failed");
    $finish;
  end

  function automatic out_item_t predict_axis_result(in_item_t it);
    out_item_t r;
    logic [7:0] low_byte;
    logic op_on;
    int unsigned ax;
    longint a, h, w;
    r = '0;
    low_byte = it.drive_status[7:0];
    op_on = (low_byte == StOpEnabled);
    ax = int'(it.axis);
    r.axis_enabled = op_on;
    if (ax >= NumAxes) begin
      r.all_enabled = chain_enabled;
      return r;
    end
    if (ax == 0) run_sweep = chain_enabled;
    if (!run_sweep) begin
      if (seen_status[ax] != it.drive_status) begin
        seen_status[ax] = it.drive_status;
        retry_left[ax] = regs.retry_reload;
      end
      if (!op_on) begin
        axis_on[ax] = 1'b0;
        if (retry_left[ax] == regs.retry_reload) begin
          if (low_byte == StSwitchOnDisabled) begin
            r.control_valid = 1'b1;
            r.control_word = CwShutdown;
          end else if (low_byte == StReadyToSwitchOn || low_byte == StReadyToSwitchOnAlt) begin
            target_hold[ax] = it.actual_position;
            r.target_valid = 1'b1;
            r.target_pos = it.actual_position;
            r.control_valid = 1'b1;
            r.control_word = CwSwitchOn;
          end else if (low_byte == StSwitchedOn) begin
            target_hold[ax] = it.actual_position;
            r.target_valid = 1'b1;
            r.target_pos = it.actual_position;
            r.control_valid = 1'b1;
            r.control_word = CwEnableOp;
          end
        end
        if (retry_left[ax] == '0) retry_left[ax] = regs.retry_reload;
        else retry_left[ax] = retry_left[ax] - 1'b1;
      end else begin
        axis_on[ax] = 1'b1;
      end
      if (ax == NumAxes - 1) chain_enabled = &axis_on;
    end else if (op_on && !at_home[ax]) begin
      a = longint'(signed'(it.actual_position));
      h = longint'(signed'(regs.home_position));
      w = longint'(regs.home_window);
      if (a > h + w) target_hold[ax] = target_hold[ax] - PosW'(regs.home_step);
      else if (a < h - w) target_hold[ax] = target_hold[ax] + PosW'(regs.home_step);
      else at_home[ax] = 1'b1;
      r.target_valid = 1'b1;
      r.target_pos = target_hold[ax];
    end
    r.all_enabled = chain_enabled;
    r.axis_homed = at_home[ax];
    return r;
  endfunction

  function automatic out_item_t outcome(logic cv, logic [CtrlW-1:0] cw, logic tv,
                                        logic [PosW-1:0] tp, logic en, logic all_on,
                                        logic hm);
    out_item_t r;
    r.control_valid = cv;
    r.control_word = cw;
    r.target_valid = tv;
    r.target_pos = tp;
    r.axis_enabled = en;
    r.all_enabled = all_on;
    r.axis_homed = hm;
    return r;
  endfunction

  function automatic step_row_t row(logic [AxisW-1:0] ax, logic [StatusW-1:0] st,
                                    logic [PosW-1:0] pos);
    step_row_t r;
    r.item.axis = ax;
    r.item.drive_status = st;
    r.item.actual_position = pos;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic step_row_t row_chk(logic [AxisW-1:0] ax, logic [StatusW-1:0] st,
                                        logic [PosW-1:0] pos, out_item_t want);
    step_row_t r;
    r = row(ax, st, pos);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic logic [StatusW-1:0] fresh_status();
    logic [7:0] lo;
    logic [7:0] hi;
    case ($urandom_range(0, 5))
      0: lo = StSwitchOnDisabled;
      1: lo = StReadyToSwitchOn;
      2: lo = StReadyToSwitchOnAlt;
      3: lo = StSwitchedOn;
      4: lo = StOpEnabled;
      default: lo = 8'($urandom);
    endcase
    hi = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
    return {hi, lo};
  endfunction

  // actual position inside or outside the home band of the current settings
  function automatic logic [PosW-1:0] place_axis(bit in_band);
    longint lo, hi, p;
    int s;
    lo = longint'(signed'(regs.home_position)) - longint'(regs.home_window);
    hi = longint'(signed'(regs.home_position)) + longint'(regs.home_window);
    if (in_band) begin
      if (lo < IntMin) lo = IntMin;
      if (hi > IntMax) hi = IntMax;
      p = lo + longint'($urandom_range(0, 32'(hi - lo)));
    end else if ($urandom_range(0, 3) == 0 && hi < IntMax) begin
      p = hi + 1;
    end else if ($urandom_range(0, 2) == 0 && lo > IntMin) begin
      p = lo - 1;
    end else begin
      do begin
        s = $urandom;
        p = longint'(s);
      end while (p >= lo && p <= hi);
    end
    return p[PosW-1:0];
  endfunction

  function automatic void check_field(string fname, logic [PosW-1:0] want,
                                      logic [PosW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, fname, want, got);
    end
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    bit took;
    out_item_t guess;
    if (!calm && gappy && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk_i);
      took = in_ready;
      @(posedge clk_i);
    end while (!took);
    guess = predict_axis_result(it);
    awaited_results.push_back(typed ? want : guess);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_registers(cfg_t c);
    cfg_we <= 1'b1;
    cfg_idx <= CfgHomePosition;
    cfg_wdata <= c.home_position;
    @(posedge clk_i);
    cfg_idx <= CfgHomeWindow;
    cfg_wdata <= CfgDataW'(c.home_window);
    @(posedge clk_i);
    cfg_idx <= CfgHomeStep;
    cfg_wdata <= CfgDataW'(c.home_step);
    @(posedge clk_i);
    cfg_idx <= CfgRetryReload;
    cfg_wdata <= CfgDataW'(c.retry_reload);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    regs = c;
  endtask

  // Whole sweeps axis 0 upwards, some cut short, with stray out-of-range items.
  // In enable sweeps one axis per sweep is kept off so the chain never enables.
  task automatic sweep_phase(int unsigned n, bit run, logic [NumAxes-1:0] homeable);
    int unsigned sent_here, blocker, last_ax;
    logic [StatusW-1:0] st;
    logic [PosW-1:0] pos;
    in_item_t it;
    sent_here = 0;
    while (sent_here < n) begin
      blocker = $urandom_range(0, NumAxes - 1);
      last_ax = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NumAxes - 2) : NumAxes - 1;
      gappy = $urandom_range(0, 1);
      for (int ax = 0; ax <= last_ax; ax++) begin
        if ($urandom_range(0, 15) == 0) begin
          it.axis = SpareAxis;
          it.drive_status = StatusW'($urandom);
          it.actual_position = $urandom;
          send_item(it, 1'b0, '0);
        end
        if (run) begin
          st = ($urandom_range(0, 6) != 0) ? {8'($urandom), StOpEnabled} : fresh_status();
          pos = place_axis(homeable[ax] && $urandom_range(0, 5) == 0);
        end else begin
          if ($urandom_range(0, 3) == 0) held_status[ax] = fresh_status();
          if (ax == blocker && held_status[ax][7:0] == StOpEnabled)
            held_status[ax][7:0] = StSwitchedOn;
          st = held_status[ax];
          if ($urandom_range(0, 7) == 0)
            pos = {($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
          else
            pos = $urandom;
        end
        it.axis = AxisW'(ax);
        it.drive_status = st;
        it.actual_position = pos;
        send_item(it, 1'b0, '0);
        sent_here++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result item expected none got %h", $time, out_item);
      end else begin
        oldest = awaited_results.pop_front();
        check_field("control_valid", PosW'(oldest.control_valid),
                    PosW'(out_item.control_valid));
        check_field("control_word", PosW'(oldest.control_word),
                    PosW'(out_item.control_word));
        check_field("target_valid", PosW'(oldest.target_valid),
                    PosW'(out_item.target_valid));
        check_field("target_pos", oldest.target_pos, out_item.target_pos);
        check_field("axis_enabled", PosW'(oldest.axis_enabled),
                    PosW'(out_item.axis_enabled));
        check_field("all_enabled", PosW'(oldest.all_enabled),
                    PosW'(out_item.all_enabled));
        check_field("axis_homed", PosW'(oldest.axis_homed),
                    PosW'(out_item.axis_homed));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    bit held_once;
    stall = 0;
    held_once = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_once && results_seen >= 250) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(posedge clk_i);
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    cfg_t c;
    regs.home_position = HomePositionReset;
    regs.home_window = HomeWindowReset;
    regs.home_step = HomeStepReset;
    regs.retry_reload = RetryReloadReset;
    for (int i = 0; i < NumAxes; i++) begin
      seen_status[i] = '0;
      retry_left[i] = RetryCountReset;
      target_hold[i] = '0;
      held_status[i] = '0;
    end
    axis_on = '0;
    at_home = '0;
    chain_enabled = 1'b0;
    run_sweep = 1'b0;

    // enable pass under reset settings
    dir_rows[0] = row_chk(SpareAxis, 16'hFF37, 32'h7FFF_FFFF,
                          outcome(0, CwNone, 0, '0, 1, 0, 0));
    dir_rows[1] = row_chk(3'd0, {8'h00, StSwitchOnDisabled}, '0,
                          outcome(1, CwShutdown, 0, '0, 0, 0, 0));
    dir_rows[2] = row_chk(3'd1, {8'h00, StReadyToSwitchOn}, 32'h7FFF_FFFF,
                          outcome(1, CwSwitchOn, 1, 32'h7FFF_FFFF, 0, 0, 0));
    dir_rows[3] = row_chk(3'd2, {8'h00, StReadyToSwitchOnAlt}, 32'h8000_0000,
                          outcome(1, CwSwitchOn, 1, 32'h8000_0000, 0, 0, 0));
    dir_rows[4] = row_chk(3'd3, {8'h00, StSwitchedOn}, 32'hFFFF_FFFF,
                          outcome(1, CwEnableOp, 1, 32'hFFFF_FFFF, 0, 0, 0));
    dir_rows[5] = row_chk(3'd4, {8'h00, StOpEnabled}, '0,
                          outcome(0, CwNone, 0, '0, 1, 0, 0));
    dir_rows[6] = row_chk(3'd5, 16'hFFFF, '0, outcome(0, CwNone, 0, '0, 0, 0, 0));
    dir_rows[7] = row_chk(3'd6, 16'h0000, 32'h5555_AAAA,
                          outcome(0, CwNone, 0, '0, 0, 0, 0));
    dir_rows[8] = row(3'd0, {8'h00, StSwitchOnDisabled}, '0);
    dir_rows[9] = row(3'd1, {8'h80, StReadyToSwitchOn}, 32'h1234_5678);
    dir_rows[10] = row(3'd4, 16'h0036, 32'hAAAA_5555);
    dir_rows[11] = row_chk(SpareAxis, 16'h0000, '0, outcome(0, CwNone, 0, '0, 0, 0, 0));
    // every axis enabled, then run pass at the top of the position range
    for (int k = 0; k < NumAxes - 1; k++)
      dir_rows[12 + k] = row_chk(AxisW'(k), {8'h00, StOpEnabled}, $urandom,
                                 outcome(0, CwNone, 0, '0, 1, 0, 0));
    dir_rows[18] = row_chk(3'd6, {8'h00, StOpEnabled}, '0, outcome(0, CwNone, 0, '0, 1, 1, 0));
    dir_rows[19] = row(3'd0, {8'h00, StOpEnabled}, 32'h8000_0000);
    dir_rows[20] = row(3'd1, {8'h00, StOpEnabled}, 32'h7FFF_FFFF);
    dir_rows[21] = row_chk(3'd2, {8'h00, StSwitchOnDisabled}, '0,
                           outcome(0, CwNone, 0, '0, 0, 1, 0));
    dir_rows[22] = row(3'd3, {8'h00, StOpEnabled}, 32'h7FFF_0000);
    dir_rows[23] = row(3'd4, {8'h00, StOpEnabled}, 32'h7FFE_FFFF);
    dir_rows[24] = row_chk(SpareAxis, {8'h00, StOpEnabled}, '0,
                           outcome(0, CwNone, 0, '0, 1, 1, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 12; i++)
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain();

    c.home_position = $urandom;
    c.home_window = WindowW'($urandom);
    c.home_step = StepW'($urandom);
    c.retry_reload = '0;
    write_registers(c);
    sweep_phase(170, 1'b0, '0);
    drain();

    c.retry_reload = '1;
    write_registers(c);
    sweep_phase(170, 1'b0, '0);
    drain();

    c.retry_reload = RetryW'($urandom_range(1, 14));
    write_registers(c);
    sweep_phase(170, 1'b0, '0);
    drain();

    c.home_position = 32'h7FFF_FFFF;
    c.home_window = '1;
    c.home_step = '1;
    c.retry_reload = 4'd3;
    write_registers(c);
    gappy = 1'b1;
    for (int i = 12; i < DirRows; i++)
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    sweep_phase(145, 1'b1, 7'b001_0001);
    drain();

    c.home_position = 32'h8000_0000;
    c.home_window = '0;
    c.home_step = 16'd1;
    c.retry_reload = RetryW'($urandom);
    write_registers(c);
    sweep_phase(155, 1'b1, 7'b000_0100);
    drain();

    c.home_position = $urandom;
    c.home_window = WindowW'($urandom);
    c.home_step = '0;
    write_registers(c);
    sweep_phase(155, 1'b1, 7'b010_0000);
    drain();

    calm = 1'b1;
    c.home_position = $urandom;
    c.home_window = WindowW'($urandom);
    c.home_step = StepW'($urandom);
    write_registers(c);
    sweep_phase(155, 1'b1, '1);
    drain();
    repeat (6) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("servo_enable_and_home_sequencer_top test passed");
    end else begin
      $display("servo_enable_and_home_sequencer_top test failed");
    end
    $finish;
  end

endmodule
